// ----- rtl/utn_pkg.sv -----
// ----------------------------------------------------------------------------
// utn_pkg: shared types and helpers for the text letter normalizer
// Item and result structs, the result group passed from the decoder to the
// output buffer, and the character folding functions.
// ----------------------------------------------------------------------------
package utn_pkg;

	localparam int unsigned MaxResults = 3;

	localparam logic [6:0] CHAR_SPACE = 7'h20;
	localparam logic [6:0] CHAR_NONE  = 7'h00;

	// one input transfer
	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} item_t;

	// one result transfer
	typedef struct packed {
		logic [6:0] out_char;
		logic       has_char;
		logic       text_last;
		logic       malformed;
	} result_t;

	// all results caused by one byte, slot 0 goes out first
	typedef struct packed {
		logic [1:0]                     cnt;
		result_t [MaxResults-1:0]       res;
	} result_group_t;

	// Latin-1 fold for units C0..FF, indexed by the low six bits; 0 = dropped
	function automatic logic [6:0] fold_char(input logic [5:0] idx);
		logic [6:0] c;
		c = CHAR_NONE;
		case (idx) inside
			[6'd0:6'd5], [6'd32:6'd37]:                 c = 7'("A");
			6'd6, 6'd38, [6'd8:6'd11], [6'd40:6'd43]:   c = 7'("E");
			6'd7, 6'd39:                                c = 7'("C");
			[6'd12:6'd15], [6'd44:6'd47]:               c = 7'("I");
			6'd16:                                      c = 7'("D");
			6'd17, 6'd49:                               c = 7'("N");
			[6'd18:6'd22], 6'd48, [6'd50:6'd54]:        c = 7'("O");
			6'd23:                                      c = 7'("X");
			[6'd25:6'd28], [6'd57:6'd60]:               c = 7'("U");
			6'd29, 6'd61, 6'd63:                        c = 7'("Y");
			6'd30, 6'd62:                               c = 7'("P");
			6'd31:                                      c = 7'("S");
			default:                                    c = CHAR_NONE;
		endcase
		return c;
	endfunction

	// kept ASCII code of a UTF-16 unit, 0 when the unit vanishes
	function automatic logic [6:0] keep_char(input logic [15:0] u);
		logic [7:0] b;
		logic [6:0] c;
		b = u[7:0];
		c = CHAR_NONE;
		if (u[15:8] == 8'h00 && u[7:6] == 2'b11) begin
			c = fold_char(u[5:0]);
		end else if (b inside {[8'h61:8'h7A]}) begin
			c = 7'(b - 8'h20);
		end else if (b inside {[8'h41:8'h5A]} || b == 8'h20) begin
			c = b[6:0];
		end
		return c;
	endfunction

endpackage

// ----- rtl/utn_decode.sv -----
// ----------------------------------------------------------------------------
// utn_decode: UTF-8 decoder, letter filter and space collapsing
// Holds the decoder and filter state. From the byte in the input register it
// builds the group of results for that byte; state advances on step.
// ----------------------------------------------------------------------------
module utn_decode (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  utn_pkg::item_t        item,
	output utn_pkg::result_group_t grp
);

	logic [1:0]  bse_q;
	logic [2:0]  seql_q;
	logic [20:0] acc_q;
	logic        sp_q;
	logic        ls_q;
	logic        err_q;

	logic [1:0]  bse_d;
	logic [2:0]  seql_d;
	logic [20:0] acc_d;
	logic        sp_d;
	logic        ls_d;
	logic        err_d;

	logic [7:0]  b;
	logic        bad;
	logic [1:0]  nunits;
	logic [15:0] units [2];
	logic [20:0] acc_new;
	logic [19:0] sup;
	logic [6:0]  c;
	logic [1:0]  n;
	utn_pkg::result_t res [utn_pkg::MaxResults];

	// decode one byte, filter the units it completes, close the text on end
	always_comb begin
		b       = item.text_byte;
		bse_d   = bse_q;
		seql_d  = seql_q;
		acc_d   = acc_q;
		sp_d    = sp_q;
		ls_d    = ls_q;
		err_d   = err_q;
		bad     = 1'b0;
		nunits  = 2'd0;
		units[0] = 16'h0000;
		units[1] = 16'h0000;
		acc_new = {acc_q[14:0], b[5:0]};
		sup     = 20'h00000;
		c       = utn_pkg::CHAR_NONE;
		n       = 2'd0;
		for (int i = 0; i < utn_pkg::MaxResults; i++) begin
			res[i] = '0;
		end

		if (!err_q) begin
			if (bse_q == 2'd0) begin
				// lead byte
				if (b < 8'h80) begin
					nunits   = 2'd1;
					units[0] = {8'h00, b};
				end else if (b < 8'hC2) begin
					bad = 1'b1;
				end else if (b < 8'hE0) begin
					seql_d = 3'd2;
					bse_d  = 2'd1;
					acc_d  = {16'h0000, b[4:0]};
				end else if (b < 8'hF0) begin
					seql_d = 3'd3;
					bse_d  = 2'd2;
					acc_d  = {17'h00000, b[3:0]};
				end else if (b < 8'hF5) begin
					seql_d = 3'd4;
					bse_d  = 2'd3;
					acc_d  = {18'h00000, b[2:0]};
				end else begin
					bad = 1'b1;
				end
			end else if (b[7:6] != 2'b10) begin
				bad = 1'b1;
			end else begin
				// first continuation: reject overlong, surrogate and out-of-range forms
				if ({1'b0, bse_q} + 3'd1 == seql_q) begin
					if (seql_q == 3'd3 && acc_q == 21'd0 && b < 8'hA0) bad = 1'b1;
					if (seql_q == 3'd3 && acc_q == 21'hD && b >= 8'hA0) bad = 1'b1;
					if (seql_q == 3'd4 && acc_q == 21'd0 && b < 8'h90) bad = 1'b1;
					if (seql_q == 3'd4 && acc_q == 21'd4 && b >= 8'h90) bad = 1'b1;
				end
				if (!bad) begin
					bse_d = bse_q - 2'd1;
					acc_d = acc_new;
					if (bse_q == 2'd1) begin
						seql_d = 3'd0;
						acc_d  = 21'd0;
						if (acc_new < 21'h10000) begin
							nunits   = 2'd1;
							units[0] = acc_new[15:0];
						end else begin
							// split into high and low surrogate
							sup      = acc_new[19:0] - 20'h10000;
							nunits   = 2'd2;
							units[0] = {6'b110110, sup[19:10]};
							units[1] = {6'b110111, sup[9:0]};
						end
					end
				end
			end
			if (bad) begin
				err_d  = 1'b1;
				bse_d  = 2'd0;
				seql_d = 3'd0;
				acc_d  = 21'd0;
			end
		end

		// letter filter with space collapsing, one unit after the other
		for (int i = 0; i < 2; i++) begin
			c = utn_pkg::keep_char(units[i]);
			if (2'(i) < nunits && c != utn_pkg::CHAR_NONE) begin
				if (c == utn_pkg::CHAR_SPACE) begin
					if (ls_d) sp_d = 1'b1;
				end else begin
					if (sp_d) begin
						res[n] = '{out_char: utn_pkg::CHAR_SPACE, has_char: 1'b1,
							text_last: 1'b0, malformed: 1'b0};
						n = n + 2'd1;
					end
					res[n] = '{out_char: c, has_char: 1'b1,
						text_last: 1'b0, malformed: 1'b0};
					n    = n + 2'd1;
					ls_d = 1'b1;
					sp_d = 1'b0;
				end
			end
		end

		// end of text: mark the last result or add a bare end marker
		if (item.end_of_text) begin
			if (bse_d != 2'd0) err_d = 1'b1;
			if (n != 2'd0) begin
				res[n - 2'd1].text_last = 1'b1;
				res[n - 2'd1].malformed = err_d;
			end else begin
				res[0] = '{out_char: utn_pkg::CHAR_NONE, has_char: 1'b0,
					text_last: 1'b1, malformed: err_d};
				n = 2'd1;
			end
			bse_d  = 2'd0;
			seql_d = 3'd0;
			acc_d  = 21'd0;
			sp_d   = 1'b0;
			ls_d   = 1'b0;
			err_d  = 1'b0;
		end

		grp.cnt = n;
		for (int i = 0; i < utn_pkg::MaxResults; i++) begin
			grp.res[i] = res[i];
		end
	end

	// decoder and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bse_q  <= 2'd0;
			seql_q <= 3'd0;
			acc_q  <= 21'd0;
			sp_q   <= 1'b0;
			ls_q   <= 1'b0;
			err_q  <= 1'b0;
		end else if (step) begin
			bse_q  <= bse_d;
			seql_q <= seql_d;
			acc_q  <= acc_d;
			sp_q   <= sp_d;
			ls_q   <= ls_d;
			err_q  <= err_d;
		end
	end

endmodule

// ----- rtl/utn_out_buf.sv -----
// ----------------------------------------------------------------------------
// utn_out_buf: result register with serializer
// Holds the result group of one byte and hands it out one transfer per cycle
// while out_ready is high, slot 0 first. Reports free when a new group may load this cycle.
// ----------------------------------------------------------------------------
module utn_out_buf (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  utn_pkg::result_group_t grp,
	output logic                   free,
	output logic                   out_valid,
	input  logic                   out_ready,
	output utn_pkg::result_t       out_data
);

	logic [1:0]       cnt_q;
	utn_pkg::result_t ent_q [utn_pkg::MaxResults];
	logic             xfer;

	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = ent_q[0];
	assign xfer      = out_valid && out_ready;
	assign free      = (cnt_q == 2'd0) || (cnt_q == 2'd1 && out_ready);

	// count of results still held
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= grp.cnt;
		end else if (xfer) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// result slots, shifted toward slot 0 on each transfer
	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < utn_pkg::MaxResults; i++) begin
				ent_q[i] <= grp.res[i];
			end
		end else if (xfer) begin
			for (int i = 0; i < utn_pkg::MaxResults - 1; i++) begin
				ent_q[i] <= ent_q[i+1];
			end
		end
	end

endmodule

// ----- rtl/utn_text_letter_normalizer_unit.sv -----
// ----------------------------------------------------------------------------
// utf8_text_letter_normalizer_unit: UTF-8 text to collapsed uppercase letters
// Decodes UTF-8 bytes, folds Latin-1 accents, keeps space and A..Z, collapses
// space runs and flags malformed input on the final result of each text.
// ----------------------------------------------------------------------------
// Usage: one byte is taken per cycle while the result register can take its
// group, and one result leaves per cycle while out_ready is high. A byte
// enters an input register, is decoded there against the stored decoder
// state and its results (zero to three) load the result register, which
// sends them out. A byte that causes no result loads nothing; one that causes
// several results holds the input side while the single result port hands them out.
// The final result of each text carries text_last and the malformed flag, and
// the decoder then starts clean for the next text.
module utf8_text_letter_normalizer_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  utn_pkg::item_t   in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output utn_pkg::result_t out_data
);

	logic                   v_s1;
	utn_pkg::item_t         item_s1;
	logic                   buf_free;
	logic                   step;
	utn_pkg::result_group_t grp;

	assign step     = v_s1 && buf_free;
	assign in_ready = !v_s1 || step;

	// input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	utn_decode u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.grp    (grp)
	);

	utn_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (step && grp.cnt != 2'd0),
		.grp       (grp),
		.free      (buf_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// ----- bench/utn_letter_checker.sv -----
// ----------------------------------------------------------------------------
// utn_letter_checker: result predictor and scoreboard for the normalizer
// Watches both channels of the unit. Every byte transfer is run through a
// local model of the UTF-8 decoder, accent fold and space filter; the
// results it causes are queued and each result transfer is compared field
// by field with the oldest queued one.
// ----------------------------------------------------------------------------
module utn_letter_checker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_ready,
	input  utn_pkg::item_t   in_data,
	input  logic             out_valid,
	input  logic             out_ready,
	input  utn_pkg::result_t out_data,
	output int               fail_count,
	output int               due_count,
	output int               results_checked,
	output int               texts_closed,
	output int               bad_texts
);

	// fold of units C0..FF, first character belongs to C0; '.' drops the unit
	localparam logic [8*64-1:0] FOLD_LUT =
		"AAAAAAECEEEEIIIIDNOOOOOX.UUUUYPSAAAAAAECEEEEIIIIONOOOOO..UUUUYPY";

	// decoder and filter state of the text in progress
	logic [1:0]  cont_left  = '0;
	logic [2:0]  seq_len    = '0;
	logic [20:0] cp_acc     = '0;
	logic        space_owed = 1'b0;
	logic        letter_out = 1'b0;
	logic        bad_text   = 1'b0;

	utn_pkg::result_t letters_due[$];
	utn_pkg::result_t byte_letters[$];

	int fails    = 0;
	int waiting  = 0;
	int checked  = 0;
	int closed   = 0;
	int flagged  = 0;

	assign fail_count      = fails;
	assign due_count       = waiting;
	assign results_checked = checked;
	assign texts_closed    = closed;
	assign bad_texts       = flagged;

	// kept ASCII code of one UTF-16 unit, CHAR_NONE if it vanishes
	function automatic logic [6:0] unit_letter(input logic [15:0] u);
		logic [7:0] lo;
		logic [7:0] f;
		int idx;
		lo = u[7:0];
		if (u >= 16'h00C0 && u <= 16'h00FF) begin
			idx = 63 - int'(u[5:0]);
			f = FOLD_LUT[8*idx +: 8];
			return (f == ".") ? utn_pkg::CHAR_NONE : f[6:0];
		end
		if (lo >= "a" && lo <= "z")
			return 7'(lo - 8'd32);
		if ((lo >= "A" && lo <= "Z") || lo == " ")
			return lo[6:0];
		return utn_pkg::CHAR_NONE;
	endfunction

	// space collapse: a space is only owed once a letter has gone out
	task automatic push_unit(input logic [15:0] u);
		logic [6:0] c;
		utn_pkg::result_t r;
		c = unit_letter(u);
		if (c == utn_pkg::CHAR_SPACE) begin
			if (letter_out)
				space_owed = 1'b1;
		end else if (c != utn_pkg::CHAR_NONE) begin
			if (space_owed) begin
				r = '{utn_pkg::CHAR_SPACE, 1'b1, 1'b0, 1'b0};
				byte_letters = {byte_letters, r};
			end
			r = '{c, 1'b1, 1'b0, 1'b0};
			byte_letters = {byte_letters, r};
			letter_out = 1'b1;
			space_owed = 1'b0;
		end
	endtask

	// code points above the BMP split into high and low surrogate units
	task automatic push_code_point(input logic [20:0] cp);
		logic [19:0] v;
		if (cp < 21'h10000) begin
			push_unit(cp[15:0]);
		end else begin
			v = 20'(cp - 21'h10000);
			push_unit({6'b110110, v[19:10]});
			push_unit({6'b110111, v[9:0]});
		end
	endtask

	// strict UTF-8 decode of one byte
	task automatic decode_text_byte(input logic [7:0] b);
		logic bad;
		bad = 1'b0;
		if (cont_left == 2'd0) begin
			if (b < 8'h80) begin
				push_unit({8'h00, b});
			end else if (b < 8'hC2) begin
				bad = 1'b1;
			end else if (b < 8'hE0) begin
				seq_len = 3'd2; cont_left = 2'd1; cp_acc = 21'(b[4:0]);
			end else if (b < 8'hF0) begin
				seq_len = 3'd3; cont_left = 2'd2; cp_acc = 21'(b[3:0]);
			end else if (b < 8'hF5) begin
				seq_len = 3'd4; cont_left = 2'd3; cp_acc = 21'(b[2:0]);
			end else begin
				bad = 1'b1;
			end
		end else if (b[7:6] != 2'b10) begin
			bad = 1'b1;
		end else begin
			// second byte: reject overlong, surrogate and beyond-U+10FFFF forms
			if ({1'b0, cont_left} + 3'd1 == seq_len) begin
				if (seq_len == 3'd3 && cp_acc == 21'h0 && b < 8'hA0) bad = 1'b1;
				if (seq_len == 3'd3 && cp_acc == 21'hD && b >= 8'hA0) bad = 1'b1;
				if (seq_len == 3'd4 && cp_acc == 21'h0 && b < 8'h90) bad = 1'b1;
				if (seq_len == 3'd4 && cp_acc == 21'h4 && b >= 8'h90) bad = 1'b1;
			end
			if (!bad) begin
				cp_acc = {cp_acc[14:0], b[5:0]};
				cont_left = cont_left - 2'd1;
				if (cont_left == 2'd0) begin
					push_code_point(cp_acc);
					seq_len = '0;
					cp_acc = '0;
				end
			end
		end
		if (bad) begin
			bad_text = 1'b1;
			cont_left = '0;
			seq_len = '0;
			cp_acc = '0;
		end
	endtask

	// results caused by one byte transfer, end of text included
	task automatic predict_byte(input utn_pkg::item_t it);
		utn_pkg::result_t r;
		byte_letters.delete();
		if (!bad_text)
			decode_text_byte(it.text_byte);
		if (it.end_of_text) begin
			if (cont_left != 2'd0)
				bad_text = 1'b1;
			if (byte_letters.size() > 0) begin
				r = byte_letters[byte_letters.size() - 1];
				byte_letters.delete(byte_letters.size() - 1);
			end else begin
				r = '{utn_pkg::CHAR_NONE, 1'b0, 1'b0, 1'b0};
			end
			r.text_last = 1'b1;
			r.malformed = bad_text;
			byte_letters = {byte_letters, r};
			cont_left = '0;
			seq_len = '0;
			cp_acc = '0;
			space_owed = 1'b0;
			letter_out = 1'b0;
			bad_text = 1'b0;
		end
		letters_due = {letters_due, byte_letters};
	endtask

	task automatic check_letter(input utn_pkg::result_t got);
		utn_pkg::result_t want;
		if (letters_due.size() == 0) begin
			$error("unexpected result: out_char %0d has_char %0d text_last %0d malformed %0d",
				got.out_char, got.has_char, got.text_last, got.malformed);
			fails++;
		end else begin
			want = letters_due.pop_front();
			if (got.out_char !== want.out_char) begin
				$error("out_char: expected %0d, actual %0d", want.out_char, got.out_char);
				fails++;
			end
			if (got.has_char !== want.has_char) begin
				$error("has_char: expected %0d, actual %0d", want.has_char, got.has_char);
				fails++;
			end
			if (got.text_last !== want.text_last) begin
				$error("text_last: expected %0d, actual %0d",
					want.text_last, got.text_last);
				fails++;
			end
			if (got.malformed !== want.malformed) begin
				$error("malformed: expected %0d, actual %0d", want.malformed, got.malformed);
				fails++;
			end
			checked++;
			if (want.text_last) begin
				closed++;
				if (want.malformed)
					flagged++;
			end
		end
	endtask

	// sample both channels on the edge at which a transfer happens
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				predict_byte(in_data);
			if (out_valid && out_ready)
				check_letter(out_data);
			waiting <= letters_due.size();
		end
	end

endmodule

// ----- bench/tb_utf8_text_letter_normalizer_unit.sv -----
// ----------------------------------------------------------------------------
// tb_utf8_text_letter_normalizer_unit: stimulus and verdict for the normalizer
// Sends a directed set of texts covering space collapse, accent folds,
// surrogate pairs and each decoder error but the overlong four-byte form, then
// random texts that are mostly valid UTF-8, with random gaps and stalls on both
// channels. Checking is done by utn_letter_checker beside the unit.
// ----------------------------------------------------------------------------
module tb_utf8_text_letter_normalizer_unit;

	localparam int QUIET_LIMIT = 3000;
	localparam int LONG_HOLD   = 80;
	localparam int ITEM_COUNT  = 350;
	localparam int SETTLE      = 8;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             in_valid  = 1'b0;
	logic             in_ready;
	utn_pkg::item_t   in_data   = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	utn_pkg::result_t out_data;

	int fail_count;
	int due_count;
	int results_checked;
	int texts_closed;
	int bad_texts;

	int   quiet        = 0;
	int   bytes_sent   = 0;
	logic tx_idle      = 1'b1;
	logic rx_idle      = 1'b1;
	logic mid_drained  = 1'b0;
	logic [7:0] text_bytes[$];

	always #5 clk = ~clk;

	utf8_text_letter_normalizer_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	utn_letter_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.in_data         (in_data),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.out_data        (out_data),
		.fail_count      (fail_count),
		.due_count       (due_count),
		.results_checked (results_checked),
		.texts_closed    (texts_closed),
		.bad_texts       (bad_texts)
	);

	// watchdog: too long without any transfer on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet <= 0;
			end else if (quiet >= QUIET_LIMIT) begin
				$display("FAIL utf8_text_letter_normalizer_unit");
				$finish;
			end else begin
				quiet <= quiet + 1;
			end
		end
	end

	function automatic int unsigned any_letter();
		return $urandom_range(0, 1) ? $urandom_range('h61, 'h7A) : $urandom_range('h41, 'h5A);
	endfunction

	task automatic put(input int unsigned v);
		logic [7:0] b;
		b = v[7:0];
		text_bytes = {text_bytes, b};
	endtask

	task automatic add_code_point(input int unsigned cp);
		if (cp < 'h80) begin
			put(cp);
		end else if (cp < 'h800) begin
			put('hC0 | (cp >> 6));
			put('h80 | (cp & 'h3F));
		end else if (cp < 'h10000) begin
			put('hE0 | (cp >> 12));
			put('h80 | ((cp >> 6) & 'h3F));
			put('h80 | (cp & 'h3F));
		end else begin
			put('hF0 | (cp >> 18));
			put('h80 | ((cp >> 12) & 'h3F));
			put('h80 | ((cp >> 6) & 'h3F));
			put('h80 | (cp & 'h3F));
		end
	endtask

	// one malformed sequence; the rest of the text is then ignored
	task automatic add_broken();
		case ($urandom_range(0, 7))
			0: put($urandom_range('h80, 'hBF));
			1: begin
				put($urandom_range('hC0, 'hC1));
				put($urandom_range('h80, 'hBF));
			end
			2: put($urandom_range('hF5, 'hFF));
			3: begin
				put('hE0);
				put($urandom_range('h80, 'h9F));
				put($urandom_range('h80, 'hBF));
			end
			4: begin
				put('hED);
				put($urandom_range('hA0, 'hBF));
				put($urandom_range('h80, 'hBF));
			end
			5: begin
				put('hF0);
				put($urandom_range('h80, 'h8F));
				put($urandom_range('h80, 'hBF));
			end
			6: begin
				put('hF4);
				put($urandom_range('h90, 'hBF));
				put($urandom_range('h80, 'hBF));
			end
			default: begin
				put($urandom_range('hC2, 'hDF));
				put($urandom_range(0, 'h7F));
			end
		endcase
	endtask

	// random text, mostly well formed
	task automatic build_text();
		int units;
		int unsigned pick, cp, hi, lo;
		text_bytes.delete();
		units = $urandom_range(1, 10);
		repeat (units) begin
			pick = $urandom_range(0, 99);
			if (pick < 30) begin
				put(any_letter());
			end else if (pick < 45) begin
				repeat ($urandom_range(1, 3)) put('h20);
			end else if (pick < 55) begin
				put($urandom_range(0, 'h7F));
			end else if (pick < 73) begin
				cp = ($urandom_range(0, 9) < 7) ? $urandom_range('hC0, 'hFF)
					: $urandom_range('h80, 'h7FF);
				add_code_point(cp);
			end else if (pick < 83) begin
				cp = $urandom_range('h800, 'hFFFF);
				if (cp >= 'hD800 && cp <= 'hDFFF)
					cp = cp ^ 'h2000;
				add_code_point(cp);
			end else if (pick < 96) begin
				hi = $urandom_range(0, 'h3FF);
				lo = $urandom_range(0, 'h3FF);
				// surrogates whose low bytes read as letters
				if ($urandom_range(0, 1)) begin
					hi = (hi & 'h300) | any_letter();
					lo = (lo & 'h300) | any_letter();
				end
				add_code_point('h10000 + (hi << 10) + lo);
			end else begin
				add_broken();
			end
		end
		// text cut off inside a sequence
		if ($urandom_range(0, 19) == 0)
			put($urandom_range('hC2, 'hF4));
	endtask

	task automatic send_byte(input logic [7:0] b, input logic eot);
		int gap;
		gap = tx_idle ? $urandom_range(0, 11) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{b, eot};
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_text();
		if ($urandom_range(0, 4) == 0)
			tx_idle = !tx_idle;
		foreach (text_bytes[i])
			send_byte(text_bytes[i], i == text_bytes.size() - 1);
	endtask

	// hold the input until every queued result has come out
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (due_count != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// receiver: random stalls, two long hold-offs to back the unit up
	initial begin
		int stall;
		int taken;
		taken = 0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (taken == 40 || taken == 150)
				stall = LONG_HOLD;
			else
				stall = rx_idle ? $urandom_range(0, 11) : 0;
			if ($urandom_range(0, 24) == 0)
				rx_idle = !rx_idle;
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			taken++;
		end
	end

	// stimulus and verdict
	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// leading, repeated and trailing spaces
		text_bytes = '{8'h20, 8'h61, 8'h20, 8'h20, 8'h5A, 8'h20};
		send_text();
		// accented, dropped and y-diaeresis folds
		text_bytes = '{8'hC3, 8'hA9, 8'hC3, 8'hB7, 8'hC3, 8'hBF};
		send_text();
		// owed space plus two letter surrogates from one byte
		text_bytes = '{8'h78, 8'h20, 8'hF0, 8'hA0, 8'h91, 8'hA2};
		send_text();
		// lone continuation, then bytes ignored after the error
		text_bytes = '{8'h80, 8'h61};
		send_text();
		// encoded surrogate
		text_bytes = '{8'hED, 8'hA0};
		send_text();
		// above U+10FFFF
		text_bytes = '{8'hF4, 8'h90};
		send_text();
		// overlong three-byte form
		text_bytes = '{8'hE0, 8'h9F};
		send_text();
		// non-continuation where one is due
		text_bytes = '{8'hC3, 8'h41};
		send_text();
		// invalid lead byte
		text_bytes = '{8'hFF};
		send_text();
		// truncated sequence at end of text
		text_bytes = '{8'hE2};
		send_text();
		drain();

		while (bytes_sent < ITEM_COUNT) begin
			build_text();
			send_text();
			if (!mid_drained && bytes_sent >= ITEM_COUNT / 2) begin
				drain();
				mid_drained = 1'b1;
			end
		end
		drain();

		$display("Sent %0d bytes; checked %0d results over %0d texts, %0d flagged malformed.",
			bytes_sent, results_checked, texts_closed, bad_texts);
		$display("Covered space collapse, accent folds, surrogates and decoder errors under stalls.");
		if (fail_count == 0 && due_count == 0) begin
			$display("PASS utf8_text_letter_normalizer_unit");
		end else begin
			$display("FAIL utf8_text_letter_normalizer_unit");
		end
		$finish;
	end

endmodule

// ----- utf8_text_letter_normalizer_unit.f -----
rtl/utn_pkg.sv
rtl/utn_decode.sv
rtl/utn_out_buf.sv
rtl/utn_text_letter_normalizer_unit.sv
bench/utn_letter_checker.sv
bench/tb_utf8_text_letter_normalizer_unit.sv
